// ----- rtl/core/grade_histogram_binning_top_macros.svh -----
// Assertion macros for the grade histogram block.
// Taken in by the checker file; no other dependencies.
`ifndef GRADE_HISTOGRAM_BINNING_TOP_MACROS_SVH
`define GRADE_HISTOGRAM_BINNING_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GHB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ghb assertion failed");

// Next-cycle implication, disabled while in reset.
`define GHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ghb assertion failed");

`endif

// ----- rtl/core/ghb_pkg.sv -----
// Shared types and constants for the grade histogram block.
// No dependencies; imported by the interfaces, the divider, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package ghb_pkg;

  localparam int GRADE_W = 8;
  localparam int NB_W    = 7;
  localparam int BND_W   = 7;
  localparam int CNT_W   = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [NB_W-1:0]  SCALE_TOP   = 7'd100;
  localparam logic [NB_W-1:0]  RESET_BINS  = 7'd10;
  localparam logic [NB_W-1:0]  RESET_WIDTH = 7'd10;  // 100 / RESET_BINS
  localparam logic [CNT_W-1:0] CNT_FULL    = 32'hFFFF_FFFF;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic REG_NUM_BINS = 1'b0;  // register index bit paddr[2]

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ghb_if.sv -----
// Valid/ready channel interfaces for the grade histogram block.
// Depends on ghb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ghb_in_if import ghb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [GRADE_W-1:0] grade;
  logic [NB_W-1:0]    bin_index;

  modport source (output valid, mode, grade, bin_index, input ready);
  modport sink   (input valid, mode, grade, bin_index, output ready);
endinterface

interface ghb_out_if import ghb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             index_ok;
  logic [BND_W-1:0] bin_low;
  logic [BND_W-1:0] bin_high;
  logic [CNT_W-1:0] bin_count;

  modport source (output valid, accepted, index_ok, bin_low, bin_high, bin_count,
                  input ready);
  modport sink   (input valid, accepted, index_ok, bin_low, bin_high, bin_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ghb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ghb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ghb_div.sv -----
// Bit-serial restoring divider: 8-bit dividend by 7-bit divisor, one
// quotient bit per cycle. Depends on ghb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ghb_div import ghb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [GRADE_W-1:0] dividend,
  input  wire logic [NB_W-1:0]    divisor,
  output      logic [GRADE_W-1:0] quotient,
  output      div_stat_t          stat
);

  localparam int CW = $clog2(GRADE_W + 1);

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [GRADE_W-1:0] rem_r, rem_nxt;
  logic [GRADE_W-1:0] quo_r, quo_nxt;
  logic [NB_W-1:0]    dvs_r, dvs_nxt;
  logic [GRADE_W-1:0] trial;
  logic               ge;

  // Remainder stays below the divisor, so the shifted trial fits 8 bits.
  assign trial = {rem_r[GRADE_W-2:0], quo_r[GRADE_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt  = CW'(GRADE_W);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt = {quo_r[GRADE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ----- rtl/core/grade_histogram_binning_top.sv -----
// Channel    Dir  Handshake          Payload
// in_chan    in   valid/ready        mode, grade, bin_index
// out_chan   out  valid/ready        accepted, index_ok, bin_low, bin_high, bin_count
// apb        in   psel/penable/pwr   num_bins at byte address 0
//
// An add runs the bit-serial divide of the grade by the bin width, then a counter
// read and write back in the bin RAM. A read passes through the RAM read and the
// output stage. Writing num_bins runs 100 / num_bins through the same divider; no
// item is taken until the new bin width is stored. Reset is synchronous, active
// low, and clears every counter at once through per-bin valid bits. A result held
// on a stalled output does not block the next transfer in; the one after waits
// for it.
// Top level of the grade histogram; uses ghb_pkg, ghb_if, ghb_div, ghb_ram.
`timescale 1ns / 1ps
`default_nettype none

module grade_histogram_binning_top import ghb_pkg::*; #(
  parameter int MAX_BINS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ghb_in_if.sink                 in_chan,
  ghb_out_if.source              out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WCALC = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [NB_W-1:0]   num_bins_r, num_bins_nxt;
  logic [NB_W-1:0]   width_r, width_nxt;
  logic              mode_r, mode_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              vld_rd_r, vld_rd_nxt;
  logic [MAX_BINS-1:0] valid_r, valid_nxt;

  logic              res_acc_r, res_acc_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [BND_W-1:0]  res_lo_r, res_lo_nxt;
  logic [BND_W-1:0]  res_hi_r, res_hi_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [BND_W-1:0]  out_lo_r, out_lo_nxt;
  logic [BND_W-1:0]  out_hi_r, out_hi_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic              cfg_wr;
  logic              in_xfer;
  logic              usable;
  logic              div_start;
  logic [GRADE_W-1:0] div_dividend;
  logic [NB_W-1:0]   div_divisor;
  logic [GRADE_W-1:0] div_quo;
  div_stat_t         div_stat;
  logic [13:0]       lo_prod;
  logic [BND_W-1:0]  lo_val;
  logic [GRADE_W-1:0] bin_n;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  ram_rdata;
  logic              ram_we;
  logic              ram_re;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_BINS);
  assign prdata = (paddr[2] == REG_NUM_BINS) ? APB_DW'(num_bins_r) : '0;

  assign usable = (num_bins_r != '0) && (num_bins_r <= SCALE_TOP)
               && ({1'b0, num_bins_r} <= 8'(MAX_BINS));

  assign in_chan.ready = (state_r == ST_IDLE) && !cfg_wr && !div_stat.busy;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  assign lo_prod = 14'(in_chan.bin_index) * 14'(width_r);
  assign lo_val  = lo_prod[BND_W-1:0];

  // Fold an index equal to the bin count into the last bin.
  assign bin_n = (div_quo == {1'b0, num_bins_r}) ? (div_quo - 1'b1) : div_quo;

  assign cur_cnt = vld_rd_r ? ram_rdata : '0;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, SCALE_TOP};
    div_divisor  = pwdata[NB_W-1:0];
    if (cfg_wr) begin
      div_start = 1'b1;
    end else if (in_xfer && usable && (in_chan.mode == MODE_ADD)) begin
      div_start    = 1'b1;
      div_dividend = in_chan.grade;
      div_divisor  = width_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    num_bins_nxt  = num_bins_r;
    width_nxt     = width_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    vld_rd_nxt    = vld_rd_r;
    valid_nxt     = valid_r;
    res_acc_nxt   = res_acc_r;
    res_ok_nxt    = res_ok_r;
    res_lo_nxt    = res_lo_r;
    res_hi_nxt    = res_hi_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_ok_nxt    = out_ok_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr) begin
          num_bins_nxt = pwdata[NB_W-1:0];
          state_nxt    = ST_WCALC;
        end else if (in_xfer) begin
          mode_nxt    = in_chan.mode;
          res_acc_nxt = 1'b0;
          res_ok_nxt  = 1'b0;
          res_lo_nxt  = '0;
          res_hi_nxt  = '0;
          res_cnt_nxt = '0;
          if (!usable) begin
            state_nxt = ST_FIN;
          end else if (in_chan.mode == MODE_ADD) begin
            state_nxt = ST_DIV;
          end else if (in_chan.bin_index < num_bins_r) begin
            addr_nxt   = in_chan.bin_index[IDX_W-1:0];
            res_ok_nxt = 1'b1;
            res_lo_nxt = lo_val;
            res_hi_nxt = (in_chan.bin_index == '0) ? (width_r - 1'b1) : (lo_val + width_r);
            state_nxt  = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_WCALC: begin
        // A later write restarts the width divide with the new count.
        if (cfg_wr) begin
          num_bins_nxt = pwdata[NB_W-1:0];
        end else if (div_stat.done) begin
          width_nxt = div_quo[NB_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (bin_n < {1'b0, num_bins_r}) begin
            addr_nxt    = bin_n[IDX_W-1:0];
            res_acc_nxt = 1'b1;
            state_nxt   = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD: begin
        ram_re     = 1'b1;
        vld_rd_nxt = valid_r[addr_r];
        state_nxt  = ST_RMW;
      end
      ST_RMW: begin
        if (mode_r == MODE_ADD) begin
          // Hold a full counter; the grade still counts as accepted.
          ram_we            = 1'b1;
          valid_nxt[addr_r] = 1'b1;
        end else begin
          res_cnt_nxt = cur_cnt;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_ok_nxt    = res_ok_r;
          out_lo_nxt    = res_lo_r;
          out_hi_nxt    = res_hi_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_bins_r  <= RESET_BINS;
      width_r     <= RESET_WIDTH;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_bins_r  <= num_bins_nxt;
      width_r     <= width_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r    <= mode_nxt;
    addr_r    <= addr_nxt;
    vld_rd_r  <= vld_rd_nxt;
    res_acc_r <= res_acc_nxt;
    res_ok_r  <= res_ok_nxt;
    res_lo_r  <= res_lo_nxt;
    res_hi_r  <= res_hi_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_acc_r <= out_acc_nxt;
    out_ok_r  <= out_ok_nxt;
    out_lo_r  <= out_lo_nxt;
    out_hi_r  <= out_hi_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  ghb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  ghb_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BINS),
    .AW    (IDX_W)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data ((cur_cnt == CNT_FULL) ? cur_cnt : (cur_cnt + 1'b1)),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.accepted  = out_acc_r;
  assign out_chan.index_ok  = out_ok_r;
  assign out_chan.bin_low   = out_lo_r;
  assign out_chan.bin_high  = out_hi_r;
  assign out_chan.bin_count = out_cnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/ghb_chk.sv -----
// Port-level checker for the grade histogram block, bound to the top level.
// Depends on ghb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "grade_histogram_binning_top_macros.svh"

module ghb_chk import ghb_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             accepted,
  input wire logic             index_ok,
  input wire logic [BND_W-1:0] bin_low,
  input wire logic [BND_W-1:0] bin_high,
  input wire logic [CNT_W-1:0] bin_count
);

  logic                         rd_fields_zero;
  logic                         out_stall;
  logic [2+2*BND_W+CNT_W-1:0]   out_payload;

  assign rd_fields_zero = (bin_low == '0) && (bin_high == '0) && (bin_count == '0);
  assign out_stall      = out_valid && !out_ready;
  assign out_payload    = {accepted, index_ok, bin_low, bin_high, bin_count};

  // One item in flight: a transfer in drops ready for the next cycle.
  `GHB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // A result never claims both an add and a good read.
  `GHB_ASSERT_IMPLY(a_mode_excl, clk, rst_n, out_valid, !(accepted && index_ok))

  // A result without index_ok (an add, or a read that misses the bin range) returns all zero fields.
  `GHB_ASSERT_IMPLY(a_bad_read_zero, clk, rst_n, out_valid && !index_ok, rd_fields_zero)

  // Hold a stalled result.
  `GHB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

endmodule

bind grade_histogram_binning_top ghb_chk u_ghb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .accepted  (out_chan.accepted),
  .index_ok  (out_chan.index_ok),
  .bin_low   (out_chan.bin_low),
  .bin_high  (out_chan.bin_high),
  .bin_count (out_chan.bin_count)
);

`default_nettype wire
